[hw/rtl/toy_cpu_instruction_step_defines.svh]
// Assertion macros shared by the checker of the instruction step block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TOY_CPU_INSTRUCTION_STEP_DEFINES_SVH
`define TOY_CPU_INSTRUCTION_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCIS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCIS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tcis_pkg.sv]
// Shared types and constants of the toy CPU instruction step block.
// No dependencies; every other file of the block but the defines header uses it.
`timescale 1ns / 1ps

package tcis_pkg;

    localparam int MEM_DEPTH_DEF = 512;
    localparam int PC_W          = 10;
    localparam int ADDR_W        = 9;
    localparam int WORD_W        = 16;
    localparam int RF_AW         = 3;
    localparam int RF_DEPTH      = 8;

    localparam logic [WORD_W-1:0] EMPTY_WORD = 16'hFFFF;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [3:0] OP_ADD   = 4'b0000;
    localparam logic [3:0] OP_SUB   = 4'b0001;
    localparam logic [3:0] OP_AND   = 4'b0010;
    localparam logic [3:0] OP_OR    = 4'b0011;
    localparam logic [3:0] OP_XOR   = 4'b0100;
    localparam logic [3:0] OP_LOAD  = 4'b0101;
    localparam logic [3:0] OP_STORE = 4'b0110;

    typedef enum logic [2:0] {
        ST_MEMW    = 3'd0,
        ST_REGW    = 3'd1,
        ST_STORE   = 3'd2,
        ST_HALT    = 3'd3,
        ST_BADXFER = 3'd4,
        ST_BADREG  = 3'd5,
        ST_BADALU  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_EXEC
    } state_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] target;
        logic [WORD_W-1:0] value;
    } res_t;

    typedef struct packed {
        logic              wr_en;
        logic [PC_W-1:0]   wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [PC_W-1:0]   rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [RF_AW-1:0]  rd_addr_a;
        logic [RF_AW-1:0]  rd_addr_b;
        logic              wr_en;
        logic [RF_AW-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } rf_req_t;

endpackage

[hw/rtl/tcis_word_mem.sv]
// Unified word memory: one write port, one registered read port, and a
// clearing pass after reset that fills every word with the empty pattern.
// Depends on tcis_pkg.
`timescale 1ns / 1ps

module tcis_word_mem #(
    parameter int MEM_DEPTH = tcis_pkg::MEM_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcis_pkg::mem_req_t             req,
    output logic [tcis_pkg::WORD_W-1:0]    rdata,
    output logic                           busy
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

    logic [tcis_pkg::WORD_W-1:0] word_ram [MEM_DEPTH];
    logic [AW-1:0]               clr_cnt_reg;
    logic                        busy_reg;
    logic [tcis_pkg::WORD_W-1:0] rdata_reg;

    // Clearing sweep: one word per cycle right after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            word_ram[clr_cnt_reg] <= tcis_pkg::EMPTY_WORD;
        end
        else if (req.wr_en)
        begin
            word_ram[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= word_ram[req.rd_addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

[hw/rtl/tcis_reg_file.sv]
// Eight-entry register file: two registered read ports, one write port.
// Entries never written since reset read as zero. Depends on tcis_pkg.
`timescale 1ns / 1ps

module tcis_reg_file (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcis_pkg::rf_req_t            req,
    output logic [tcis_pkg::WORD_W-1:0]  rdata_a,
    output logic [tcis_pkg::WORD_W-1:0]  rdata_b
);

    logic [tcis_pkg::WORD_W-1:0]   regs [tcis_pkg::RF_DEPTH];
    logic [tcis_pkg::RF_DEPTH-1:0] valid_reg;
    logic                          hit_a_reg;
    logic                          hit_b_reg;
    logic [tcis_pkg::WORD_W-1:0]   data_a_reg;
    logic [tcis_pkg::WORD_W-1:0]   data_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_a_reg <= valid_reg[req.rd_addr_a];
                hit_b_reg <= valid_reg[req.rd_addr_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            regs[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_a_reg <= regs[req.rd_addr_a];
            data_b_reg <= regs[req.rd_addr_b];
        end
    end

    // Mask entries that still hold their reset value
    assign rdata_a = hit_a_reg ? data_a_reg : '0;
    assign rdata_b = hit_b_reg ? data_b_reg : '0;

endmodule

[hw/rtl/tcis_seq.sv]
// Instruction sequencer: program counter, stop flag, decode, ALU, and the
// read-modify-write sequence over the word memory and register file.
// Depends on tcis_pkg.
`timescale 1ns / 1ps

module tcis_seq #(
    parameter int MEM_DEPTH = tcis_pkg::MEM_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  tcis_pkg::cmd_t               item,
    output logic                         item_take,
    input  logic                         out_free,
    output logic                         emit,
    output tcis_pkg::res_t               result,
    output tcis_pkg::mem_req_t           mem_req,
    input  logic [tcis_pkg::WORD_W-1:0]  mem_rdata,
    output tcis_pkg::rf_req_t            rf_req,
    input  logic [tcis_pkg::WORD_W-1:0]  rf_rdata_a,
    input  logic [tcis_pkg::WORD_W-1:0]  rf_rdata_b
);

    localparam int PW = tcis_pkg::PC_W;
    localparam logic [PW:0] DEPTH_L = (PW + 1)'(MEM_DEPTH);

    tcis_pkg::state_t              state_reg;
    tcis_pkg::state_t              state_next;
    logic [PW-1:0]                 pc_reg;
    logic [PW-1:0]                 pc_next;
    logic                          stopped_reg;
    logic                          stopped_next;
    logic [tcis_pkg::ADDR_W-1:0]   ipc_reg;
    logic [tcis_pkg::ADDR_W-1:0]   ipc_next;
    logic [tcis_pkg::WORD_W-1:0]   instr_reg;
    logic [tcis_pkg::WORD_W-1:0]   instr_next;

    logic [tcis_pkg::WORD_W-1:0]   dec_word;
    logic [2:0]                    dec_rc;
    logic [3:0]                    dec_rb;
    logic [2:0]                    dec_ra;
    logic                          dec_imm;
    logic [3:0]                    dec_opc;
    logic                          dec_tbit;
    logic                          dec_go;
    tcis_pkg::status_t             dec_err;
    logic [tcis_pkg::WORD_W-1:0]   alu_x;
    logic [tcis_pkg::WORD_W-1:0]   alu_res;

    // Decode the fetched word in DECODE, the held word in EXEC
    assign dec_word = (state_reg == tcis_pkg::SQ_DECODE) ? mem_rdata : instr_reg;
    assign dec_rc   = dec_word[2:0];
    assign dec_rb   = dec_word[6:3];
    assign dec_ra   = dec_word[9:7];
    assign dec_imm  = dec_word[10];
    assign dec_opc  = dec_word[14:11];
    assign dec_tbit = dec_word[15];

    assign alu_x = dec_imm ? {12'b0, dec_rb} : rf_rdata_a;

    always_comb
    begin
        case (dec_opc)
            tcis_pkg::OP_ADD: alu_res = alu_x + rf_rdata_b;
            tcis_pkg::OP_SUB: alu_res = alu_x - rf_rdata_b;
            tcis_pkg::OP_AND: alu_res = alu_x & rf_rdata_b;
            tcis_pkg::OP_OR:  alu_res = alu_x | rf_rdata_b;
            tcis_pkg::OP_XOR: alu_res = alu_x ^ rf_rdata_b;
            default:          alu_res = '0;
        endcase
    end

    // Legality check; a bad register operand wins over a bad ALU opcode
    always_comb
    begin
        dec_go  = 1'b0;
        dec_err = tcis_pkg::ST_BADXFER;
        if (dec_tbit)
        begin
            dec_go = (dec_opc == tcis_pkg::OP_LOAD) || (dec_opc == tcis_pkg::OP_STORE);
        end
        else if (!dec_imm && dec_rb[3])
        begin
            dec_err = tcis_pkg::ST_BADREG;
        end
        else if (dec_opc inside {[tcis_pkg::OP_ADD:tcis_pkg::OP_XOR]})
        begin
            dec_go = 1'b1;
        end
        else
        begin
            dec_err = tcis_pkg::ST_BADALU;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        ipc_next     = ipc_reg;
        instr_next   = instr_reg;
        item_take    = 1'b0;
        emit         = 1'b0;
        result       = '0;
        mem_req      = '0;
        rf_req       = '0;

        case (state_reg)
            tcis_pkg::SQ_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.action == tcis_pkg::ACT_WRITE)
                    begin
                        emit          = 1'b1;
                        result.status = tcis_pkg::ST_MEMW;
                        result.target = item.address;
                        result.value  = item.data;
                        if (out_free)
                        begin
                            item_take       = 1'b1;
                            mem_req.wr_en   = ({2'b0, item.address} < DEPTH_L);
                            mem_req.wr_addr = {1'b0, item.address};
                            mem_req.wr_data = item.data;
                        end
                    end
                    else if (stopped_reg || ({1'b0, pc_reg} >= DEPTH_L))
                    begin
                        emit          = 1'b1;
                        result.status = tcis_pkg::ST_HALT;
                        result.pc     = pc_reg[tcis_pkg::ADDR_W-1:0];
                        if (out_free)
                        begin
                            item_take    = 1'b1;
                            stopped_next = 1'b1;
                        end
                    end
                    else
                    begin
                        item_take       = 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = pc_reg;
                        ipc_next        = pc_reg[tcis_pkg::ADDR_W-1:0];
                        state_next      = tcis_pkg::SQ_DECODE;
                    end
                end
            end

            tcis_pkg::SQ_DECODE:
            begin
                result.pc = ipc_reg;
                if (dec_word == tcis_pkg::EMPTY_WORD)
                begin
                    emit          = 1'b1;
                    result.status = tcis_pkg::ST_HALT;
                    if (out_free)
                    begin
                        stopped_next = 1'b1;
                        state_next   = tcis_pkg::SQ_IDLE;
                    end
                end
                else if (dec_go)
                begin
                    mem_req.rd_en    = dec_tbit;
                    mem_req.rd_addr  = {6'b0, dec_rb};
                    rf_req.rd_en     = 1'b1;
                    rf_req.rd_addr_a = dec_tbit ? dec_ra : dec_rb[2:0];
                    rf_req.rd_addr_b = dec_rc;
                    instr_next       = dec_word;
                    pc_next          = pc_reg + PW'(1);
                    state_next       = tcis_pkg::SQ_EXEC;
                end
                else
                begin
                    emit          = 1'b1;
                    result.status = dec_err;
                    if (out_free)
                    begin
                        pc_next      = pc_reg + PW'(1);
                        stopped_next = 1'b1;
                        state_next   = tcis_pkg::SQ_IDLE;
                    end
                end
            end

            tcis_pkg::SQ_EXEC:
            begin
                emit      = 1'b1;
                result.pc = ipc_reg;
                if (dec_tbit && (dec_opc == tcis_pkg::OP_STORE))
                begin
                    result.status   = tcis_pkg::ST_STORE;
                    result.target   = {5'b0, dec_rb};
                    result.value    = rf_rdata_a;
                    mem_req.wr_en   = out_free;
                    mem_req.wr_addr = {6'b0, dec_rb};
                    mem_req.wr_data = rf_rdata_a;
                end
                else
                begin
                    result.status  = tcis_pkg::ST_REGW;
                    result.target  = {6'b0, dec_ra};
                    result.value   = dec_tbit ? mem_rdata : alu_res;
                    rf_req.wr_en   = out_free;
                    rf_req.wr_addr = dec_ra;
                    rf_req.wr_data = dec_tbit ? mem_rdata : alu_res;
                end
                if (out_free)
                begin
                    state_next = tcis_pkg::SQ_IDLE;
                end
            end

            default:
            begin
                state_next = tcis_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tcis_pkg::SQ_IDLE;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ipc_reg   <= ipc_next;
        instr_reg <= instr_next;
    end

endmodule

[hw/rtl/toy_cpu_instruction_step.sv]
// Top level of the toy CPU instruction step block: command holding stage,
// sequencer, word memory, register file and result register.
// Depends on tcis_pkg, tcis_word_mem, tcis_reg_file and tcis_seq.
//
//   channel | handshake            | payload         | direction
//   --------+----------------------+-----------------+----------
//   cmd     | cmd_valid/cmd_ready  | tcis_pkg::cmd_t | into block
//   res     | res_valid/res_ready  | tcis_pkg::res_t | out of block
//
// A memory write command is handled in the idle state of the sequencer; an
// instruction step runs through fetch, decode with operand read, and execute
// with write-back. Halts and stopped steps finish in the idle state, empty
// words and decode errors in the decode state.
// After reset the word memory is swept to 0xFFFF, one word a cycle, so
// cmd_ready stays low until the sweep ends.
// A held result stalls the sequencer only when it has another result to
// deliver; one further command waits in the holding stage meanwhile.
`timescale 1ns / 1ps

module toy_cpu_instruction_step #(
    parameter int MEM_DEPTH = tcis_pkg::MEM_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  tcis_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output tcis_pkg::res_t res
);

    // Command holding stage
    logic           buf_valid_reg;
    tcis_pkg::cmd_t buf_reg;

    // Result register
    logic           res_valid_reg;
    tcis_pkg::res_t res_reg;

    // Sequencer hookup
    logic                         item_take;
    logic                         out_free;
    logic                         emit;
    tcis_pkg::res_t               result;
    tcis_pkg::mem_req_t           mem_req;
    logic [tcis_pkg::WORD_W-1:0]  mem_rdata;
    logic                         mem_busy;
    tcis_pkg::rf_req_t            rf_req;
    logic [tcis_pkg::WORD_W-1:0]  rf_rdata_a;
    logic [tcis_pkg::WORD_W-1:0]  rf_rdata_b;

    // Take a command only into an empty holding stage and never during the sweep
    assign cmd_ready = !buf_valid_reg && !mem_busy;

    // The result register is free once empty or being drained this cycle
    assign out_free = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Hold the command until the sequencer picks it up
            if (cmd_valid && cmd_ready)
            begin
                buf_valid_reg <= 1'b1;
            end
            else if (item_take)
            begin
                buf_valid_reg <= 1'b0;
            end

            // Advance a new result in, or drop the one just transferred
            if (emit && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            buf_reg <= cmd;
        end
        if (emit && out_free)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    tcis_seq #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (buf_valid_reg),
        .item       (buf_reg),
        .item_take  (item_take),
        .out_free   (out_free),
        .emit       (emit),
        .result     (result),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .rf_req     (rf_req),
        .rf_rdata_a (rf_rdata_a),
        .rf_rdata_b (rf_rdata_b)
    );

    tcis_word_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_word_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    tcis_reg_file u_reg_file (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rf_req),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b)
    );

endmodule

[hw/rtl/tcis_checker.sv]
// Port-level checker for the toy CPU instruction step block, bound to the top.
// Depends on tcis_pkg and toy_cpu_instruction_step_defines.svh.
`timescale 1ns / 1ps
`include "toy_cpu_instruction_step_defines.svh"

module tcis_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input tcis_pkg::cmd_t cmd,
    input logic           res_valid,
    input logic           res_ready,
    input tcis_pkg::res_t res
);

    // A stalled result holds until its transfer
    `TCIS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

    // Memory writes carry no program counter
    `TCIS_ASSERT_IMP(a_memw_pc, res_valid && res.status == tcis_pkg::ST_MEMW, res.pc == '0, "memory write result with nonzero pc")

    // Halts and errors write nothing
    `TCIS_ASSERT_IMP(a_stop_zero, res_valid && (res.status == tcis_pkg::ST_HALT || res.status == tcis_pkg::ST_BADXFER || res.status == tcis_pkg::ST_BADREG || res.status == tcis_pkg::ST_BADALU), res.target == '0 && res.value == '0, "stop result with nonzero target or value")

    // Only one command waits ahead of the sequencer
    `TCIS_ASSERT_NXT(a_one_held, cmd_valid && cmd_ready, !cmd_ready, "command taken back to back into a full stage")

endmodule

bind toy_cpu_instruction_step tcis_checker u_tcis_checker (.*);
